// ===== hdl/id_lock_manager_fifo_macros.svh =====
// Assertion macros shared by the lock manager RTL.
// Expects signals clk and rst_n in the scope where a macro is used.
`ifndef ID_LOCK_MANAGER_FIFO_MACROS_SVH
`define ID_LOCK_MANAGER_FIFO_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ILMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define ILMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ilmf_pkg.sv =====
// Shared types and codes for the lock manager with FIFO wait queue.
// No dependencies.
package ilmf_pkg;

    // Request selector
    localparam logic REQ_ACQUIRE = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_GRANTED   = 3'd0,
        ST_ALREADY   = 3'd1,
        ST_QUEUED    = 3'd2,
        ST_FULL      = 3'd3,
        ST_FREED     = 3'd4,
        ST_HANDED    = 3'd5,
        ST_NOT_OWNER = 3'd6
    } status_t;

    localparam int ID_W      = 8;
    localparam int WAITERS_W = 5;

    typedef struct packed {
        logic            req_type;
        logic [ID_W-1:0] client_id;
        logic [ID_W-1:0] thread_id;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [ID_W-1:0]      next_client;
        logic [ID_W-1:0]      next_thread;
        logic                 busy_after;
        logic                 requester_held;
        logic [WAITERS_W-1:0] waiters;
    } res_t;

endpackage

// ===== hdl/ilmf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ilmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read the array
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/ilmf_core.sv =====
// Lock state, owner registers and wait FIFO pointers; decides one request per cycle.
// Depends on ilmf_pkg, ilmf_ram and the assertion macro header.
`include "id_lock_manager_fifo_macros.svh"

module ilmf_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  ilmf_pkg::req_t in_req,
    output ilmf_pkg::res_t out_res
);
    import ilmf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ENT_W = 2 * ID_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic             busy_reg, busy_next;
    logic [ID_W-1:0]  own_client_reg, own_client_next;
    logic [ID_W-1:0]  own_thread_reg, own_thread_next;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             byp_vld_reg, byp_vld_next;
    logic [ENT_W-1:0] byp_data_reg;

    logic             wr_en;
    logic [ENT_W-1:0] wr_data;
    logic [ENT_W-1:0] rd_data;
    logic [ENT_W-1:0] head_ent;
    logic             held;
    logic             pop;
    logic [31:0]      cnt_ext;

    // Wait entries: client in the upper byte, thread in the lower byte
    ilmf_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_wait_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

    // Take the head entry from the bypass when it was written on the last edge
    assign head_ent = byp_vld_reg ? byp_data_reg : rd_data;
    assign wr_data  = {in_req.client_id, in_req.thread_id};
    assign held     = busy_reg && (own_client_reg == in_req.client_id)
                      && (own_thread_reg == in_req.thread_id);

    // Decide the request and compute next state
    always_comb
    begin
        busy_next       = busy_reg;
        own_client_next = own_client_reg;
        own_thread_next = own_thread_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        wr_en           = 1'b0;
        pop             = 1'b0;
        out_res.status      = ST_NOT_OWNER;
        out_res.next_client = '0;
        out_res.next_thread = '0;

        if (in_req.req_type == REQ_ACQUIRE)
        begin
            if (held)
            begin
                out_res.status = ST_ALREADY;
            end
            else if (!busy_reg)
            begin
                busy_next       = in_vld;
                own_client_next = in_vld ? in_req.client_id : own_client_reg;
                own_thread_next = in_vld ? in_req.thread_id : own_thread_reg;
                out_res.status  = ST_GRANTED;
            end
            else if (cnt_reg < CNT_FULL)
            begin
                wr_en          = in_vld;
                out_res.status = ST_QUEUED;
            end
            else
            begin
                out_res.status = ST_FULL;
            end
        end
        else
        begin
            if (!busy_reg || (own_client_reg != in_req.client_id))
            begin
                out_res.status = ST_NOT_OWNER;
            end
            else if (cnt_reg != '0)
            begin
                pop                 = in_vld;
                out_res.next_client = head_ent[ENT_W-1:ID_W];
                out_res.next_thread = head_ent[ID_W-1:0];
                out_res.status      = ST_HANDED;
                if (in_vld)
                begin
                    own_client_next = head_ent[ENT_W-1:ID_W];
                    own_thread_next = head_ent[ID_W-1:0];
                end
            end
            else
            begin
                out_res.status = ST_FREED;
                if (in_vld)
                begin
                    busy_next       = 1'b0;
                    own_client_next = '0;
                    own_thread_next = '0;
                end
            end
        end

        // Advance the FIFO pointers, wrapping at the last entry
        if (wr_en)
        begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            cnt_next  = cnt_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
            cnt_next  = cnt_reg - 1'b1;
        end

        cnt_ext                = 32'(cnt_next);
        out_res.busy_after     = busy_next;
        out_res.requester_held = held;
        out_res.waiters        = cnt_ext[WAITERS_W-1:0];
    end

    // Flag a write into the entry the RAM is reading on the same edge
    assign byp_vld_next = wr_en && (tail_reg == head_next);

    // Hold lock and queue state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            own_client_reg <= '0;
            own_thread_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            cnt_reg        <= '0;
            byp_vld_reg    <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            own_client_reg <= own_client_next;
            own_thread_reg <= own_thread_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            cnt_reg        <= cnt_next;
            byp_vld_reg    <= byp_vld_next;
        end
    end

    // Capture the bypass entry
    always_ff @(posedge clk)
    begin
        byp_data_reg <= wr_data;
    end

    `ILMF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_FULL, "wait count above queue depth")
    `ILMF_ASSERT_NOW(a_free_empty, !busy_reg, cnt_reg == '0, "waiters queued on a free lock")
    `ILMF_ASSERT_NEXT(a_pop_count, pop, cnt_reg == $past(cnt_reg) - 1'b1, "pop did not drop count")

endmodule

// ===== hdl/id_lock_manager_fifo.sv =====
// Top level of the lock manager with FIFO wait queue: request and result registers.
// Depends on ilmf_pkg, ilmf_core and the assertion macro header.
//
// A request is taken at each rising edge with start high and busy low; busy is
// high only in the first cycle after reset, so one request per cycle is taken.
// The request is registered, decided against the lock state in the next cycle,
// and its result shows on res with done high for the one cycle that follows
// the next edge. Results come out in request order and cannot be held off:
// the receiver must take each one in the cycle that done marks. The wait queue
// is a RAM of QUEUE_DEPTH entries whose head read is registered; a write into
// the head entry is forwarded so back-to-back requests see it.
`include "id_lock_manager_fifo_macros.svh"

module id_lock_manager_fifo #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ilmf_pkg::req_t req,
    output logic           done,
    output ilmf_pkg::res_t res
);
    import ilmf_pkg::*;

    logic busy_reg;
    logic vld_reg, vld_next;
    req_t req_reg;
    logic done_reg;
    res_t res_reg;
    res_t core_res;

    assign vld_next = start && !busy_reg;

    // Hold off requests for one cycle out of reset; advance the valid pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            vld_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= 1'b0;
            vld_reg  <= vld_next;
            done_reg <= vld_reg;
        end
    end

    // Capture the request and the decided result
    always_ff @(posedge clk)
    begin
        if (vld_next)
        begin
            req_reg <= req;
        end
        if (vld_reg)
        begin
            res_reg <= core_res;
        end
    end

    ilmf_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (vld_reg),
        .in_req  (req_reg),
        .out_res (core_res)
    );

    assign busy = busy_reg;
    assign done = done_reg;
    assign res  = res_reg;

    `ILMF_ASSERT_NEXT(a_req_to_done, vld_reg, done, "decided request gave no result strobe")
    `ILMF_ASSERT_NOW(a_hand_busy, done && (res.status == ST_HANDED),
        res.busy_after, "hand over left lock free")
    `ILMF_ASSERT_NOW(a_free_idle, done && (res.status == ST_FREED),
        !res.busy_after && (res.waiters == '0), "freed lock still held")

endmodule

// ===== dv/id_lock_manager_fifo_tb.sv =====
// Testbench for id_lock_manager_fifo: directed and random lock requests, checked
// field by field against a predictor of the lock and its wait FIFO.
// Depends on ilmf_pkg and the id_lock_manager_fifo RTL.
`timescale 1ns / 1ps

module id_lock_manager_fifo_tb;

    import ilmf_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_PHASES  = 5;
    localparam int PHASE_ITEMS = 250;

    // Predicts the lock owner and wait FIFO and checks each result in order
    class lock_tracker;
        logic              lock_busy;
        logic [ID_W-1:0]   owner_client;
        logic [ID_W-1:0]   owner_thread;
        logic [ID_W-1:0]   wait_client [QUEUE_DEPTH];
        logic [ID_W-1:0]   wait_thread [QUEUE_DEPTH];
        int unsigned       queue_head;
        int unsigned       queue_tail;
        int unsigned       queue_count;
        res_t              expected_results [$];
        int                errors;

        function new();
            lock_busy    = 1'b0;
            owner_client = '0;
            owner_thread = '0;
            queue_head   = 0;
            queue_tail   = 0;
            queue_count  = 0;
            errors       = 0;
        endfunction

        function void report(string msg);
            $display("ERROR at %0t ns: %s", $time, msg);
            errors++;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Advance the lock state by one request and queue its expected result
        function void note_request(req_t r);
            res_t exp;
            logic held;
            held = lock_busy && owner_client == r.client_id && owner_thread == r.thread_id;
            exp.next_client = '0;
            exp.next_thread = '0;
            if (r.req_type == REQ_ACQUIRE)
            begin
                if (held)
                    exp.status = ST_ALREADY;
                else if (!lock_busy)
                begin
                    lock_busy    = 1'b1;
                    owner_client = r.client_id;
                    owner_thread = r.thread_id;
                    exp.status   = ST_GRANTED;
                end
                else if (queue_count < QUEUE_DEPTH)
                begin
                    wait_client[queue_tail] = r.client_id;
                    wait_thread[queue_tail] = r.thread_id;
                    queue_tail = (queue_tail + 1) % QUEUE_DEPTH;
                    queue_count++;
                    exp.status = ST_QUEUED;
                end
                else
                    exp.status = ST_FULL;
            end
            else
            begin
                // Only the client is compared on release
                if (!lock_busy || owner_client != r.client_id)
                    exp.status = ST_NOT_OWNER;
                else if (queue_count > 0)
                begin
                    exp.next_client = wait_client[queue_head];
                    exp.next_thread = wait_thread[queue_head];
                    queue_head   = (queue_head + 1) % QUEUE_DEPTH;
                    queue_count--;
                    owner_client = exp.next_client;
                    owner_thread = exp.next_thread;
                    exp.status   = ST_HANDED;
                end
                else
                begin
                    lock_busy    = 1'b0;
                    owner_client = '0;
                    owner_thread = '0;
                    exp.status   = ST_FREED;
                end
            end
            exp.busy_after     = lock_busy;
            exp.requester_held = held;
            exp.waiters        = queue_count[WAITERS_W-1:0];
            expected_results.push_back(exp);
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(res_t got);
            res_t exp;
            if (expected_results.size() == 0)
            begin
                report($sformatf("result with no request outstanding, status %0d", got.status));
                return;
            end
            exp = expected_results.pop_front();
            if (got.status !== exp.status)
                report($sformatf("status %0d, expected %0d", got.status, exp.status));
            if (got.next_client !== exp.next_client)
                report($sformatf("next_client %0d, expected %0d",
                                 got.next_client, exp.next_client));
            if (got.next_thread !== exp.next_thread)
                report($sformatf("next_thread %0d, expected %0d",
                                 got.next_thread, exp.next_thread));
            if (got.busy_after !== exp.busy_after)
                report($sformatf("busy_after %b, expected %b", got.busy_after, exp.busy_after));
            if (got.requester_held !== exp.requester_held)
                report($sformatf("requester_held %b, expected %b",
                                 got.requester_held, exp.requester_held));
            if (got.waiters !== exp.waiters)
                report($sformatf("waiters %0d, expected %0d", got.waiters, exp.waiters));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    res_t res;

    lock_tracker tracker;

    logic [ID_W-1:0] pool_client [6];
    logic [ID_W-1:0] pool_thread [6];

    id_lock_manager_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .res   (res)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // Check results and note accepted requests at each rising edge
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_result(res);
        if (rst_n && start && !busy)
            tracker.note_request(req);
    end

    // Hold one request until it is taken; return at the following falling edge
    task send_request(input req_t r);
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Drop start and hold off until every expected result has come or the wait limit runs out
    task wait_drained();
        int n;
        n = 0;
        start <= 1'b0;
        while (tracker.pending() != 0 && n < 200)
        begin
            @(negedge clk);
            n++;
        end
    endtask

    function automatic req_t make_req(logic kind, logic [ID_W-1:0] c, logic [ID_W-1:0] t);
        req_t r;
        r.req_type  = kind;
        r.client_id = c;
        r.thread_id = t;
        return r;
    endfunction

    // Walk through every status but freed, the id extremes and a full wait queue
    task run_directed();
        int i;
        send_request(make_req(REQ_RELEASE, 8'd0, 8'd0));       // release when free
        send_request(make_req(REQ_ACQUIRE, 8'd0, 8'd0));       // grant to a free lock
        send_request(make_req(REQ_ACQUIRE, 8'd0, 8'd0));       // owner acquires again
        send_request(make_req(REQ_RELEASE, 8'd255, 8'd0));     // release by another client
        for (i = 0; i < QUEUE_DEPTH; i++)
            send_request(make_req(REQ_ACQUIRE, 8'(i * 17), 8'(255 - i * 17)));
        send_request(make_req(REQ_ACQUIRE, 8'd255, 8'd255));   // queue full, dropped
        send_request(make_req(REQ_RELEASE, 8'd0, 8'd7));       // other thread of owner client
        send_request(make_req(REQ_RELEASE, 8'd0, 8'd255));     // new owner hands over again
        send_request(make_req(REQ_ACQUIRE, 8'd17, 8'd238));    // new owner acquires again
    endtask

    // Mostly pool ids so owners match; releases lean toward the current owner
    function automatic req_t pick_request(int acquire_pct);
        req_t r;
        int   idx;
        idx         = $urandom_range(0, 5);
        r.client_id = pool_client[idx];
        r.thread_id = pool_thread[idx];
        if ($urandom_range(0, 9) == 0)
        begin
            r.client_id = ID_W'($urandom_range(0, 255));
            r.thread_id = ID_W'($urandom_range(0, 255));
        end
        if ($urandom_range(0, 99) < acquire_pct)
            r.req_type = REQ_ACQUIRE;
        else
        begin
            r.req_type = REQ_RELEASE;
            if (tracker.lock_busy && $urandom_range(0, 3) != 0)
            begin
                r.client_id = tracker.owner_client;
                if ($urandom_range(0, 1) == 1)
                    r.thread_id = tracker.owner_thread;
            end
        end
        return r;
    endfunction

    // Send requests in bursts with random gaps between them
    task run_random(input int count, input int acquire_pct);
        int left;
        int burst;
        int i;
        left = count;
        for (i = 0; i < 3; i++)
        begin
            pool_client[i]     = ID_W'($urandom_range(0, 255));
            pool_client[i + 3] = pool_client[i];
        end
        for (i = 0; i < 6; i++)
            pool_thread[i] = ID_W'($urandom_range(0, 255));
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0)
            begin
                send_request(pick_request(acquire_pct));
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        int acquire_mix [NUM_PHASES];
        int p;
        acquire_mix = '{50, 80, 30, 65, 90};
        tracker = new();
        start   = 1'b0;
        req     = '0;
        rst_n   = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        wait_drained();
        for (p = 0; p < NUM_PHASES; p++)
        begin
            run_random(PHASE_ITEMS, acquire_mix[p]);
            wait_drained();
        end

        // Let any late result show up
        repeat (8) @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d expected results never arrived", tracker.pending()));
        if (tracker.errors == 0)
            $display("id_lock_manager_fifo test passed");
        else
            $display("id_lock_manager_fifo test failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5ms;
        $display("id_lock_manager_fifo test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/ilmf_pkg.sv
hdl/ilmf_ram.sv
hdl/ilmf_core.sv
hdl/id_lock_manager_fifo.sv
dv/id_lock_manager_fifo_tb.sv
